>>> hdl/nllt_pkg.sv
// Package for the next-hop latency and loss tracker.
// Holds event codes, divider operation codes, fixed-point constants and the
// command/status structs shared by the controller and the datapath.
package nllt_pkg;

  localparam int RTT_INT_BITS       = 20;
  localparam int RTT_FRAC_BITS      = 8;
  localparam int RTT_W              = RTT_INT_BITS + RTT_FRAC_BITS;
  localparam int COUNTER_BITS_DEF   = 16;
  localparam int FUNC_W             = 4;
  localparam int ROUND_W            = 32;
  localparam int LOSS_W             = 16;
  localparam int SILENT_W           = 8;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int IN_TDATA_W         = 56;
  localparam int OUT_TDATA_W        = 152;

  localparam logic [7:0]  MAX_SILENT_RST = 8'd4;
  localparam logic [7:0]  MIN_CLEAN_RST  = 8'd10;
  localparam logic [15:0] MAX_LOSS_RST   = 16'd6554;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SILENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLEAN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOSS   = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_RTT        = 4'd0,
    FN_PKT        = 4'd1,
    FN_PROBE_SENT = 4'd2,
    FN_PROBE_LOST = 4'd3,
    FN_ROUND      = 4'd4,
    FN_TRY_SWITCH = 4'd5,
    FN_CLR_SWITCH = 4'd6,
    FN_UNUSED     = 4'd7,
    FN_ALLOW      = 4'd8,
    FN_QUERY      = 4'd9,
    FN_RESET      = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    OP_RTT   = 2'd0,
    OP_RATIO = 2'd1,
    OP_LOSS  = 2'd2,
    OP_QUEUE = 2'd3
  } div_op_t;

  typedef struct packed {
    logic    load;
    logic    apply;
    logic    div_start;
    div_op_t start_op;
    logic    commit;
    div_op_t commit_op;
    logic    queue_one;
    logic    form;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              tgt_valid;
    logic              both_valid;
    logic              sent_nz;
    logic              div_done;
    logic              out_free;
  } dp_status_t;

endpackage

>>> hdl/nllt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package items; computes the per-round loss ratio.
module nllt_div #(
  parameter int NW = 34,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(NW);
      quo_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      quo_r <= {quo_r[NW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> hdl/nllt_dp.sv
// Datapath: tracker state, configuration registers, the loss ratio divider,
// the constant dividers and the output register. Depends on nllt_pkg and nllt_div.
module nllt_dp #(
  parameter int COUNTER_BITS = nllt_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nllt_pkg::dp_cmd_t                   cmd,
  output nllt_pkg::dp_status_t                sts,
  input  logic [nllt_pkg::FUNC_W-1:0]         in_tuser,
  input  logic [nllt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_we,
  input  logic [nllt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nllt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nllt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import nllt_pkg::*;

  localparam int CB     = COUNTER_BITS;
  localparam int DIV_NW = CB + 16;
  // ceil(2^34 / 5): exact n/5 and n/10 for any 32-bit n
  localparam logic [31:0] K_RECIP = 32'hCCCC_CCCD;

  logic [7:0]        max_silent_r, min_clean_r;
  logic [15:0]       max_loss_r;

  logic [FUNC_W-1:0] func_r;
  logic [19:0]       rtt_r;
  logic [ROUND_W-1:0] round_r;
  logic              allow_r;

  logic              in_use_r, allowed_r;
  logic [CB-1:0]     pkts_r, switch_cnt_r, probes_rx_r, sent_r, lost_r;
  logic [ROUND_W-1:0] last_round_r;
  logic [7:0]        silent_r, clean_r;
  logic [RTT_W-1:0]  probe_avg_r, use_avg_r, queue_r;
  logic              probe_vld_r, use_vld_r;
  logic [LOSS_W-1:0] loss_r;

  logic              out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [RTT_W-1:0]  sample, tgt_avg, qdiff;
  logic              tgt_vld;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic              div_go, div_done;
  logic [33:0]       k_sum;
  logic [31:0]       k_num, k_num_r;
  logic              k_by10, k_by10_r, k_run_r, k_done_r;
  logic [63:0]       k_prod_r;
  logic [RTT_W-1:0]  k_quo;
  logic [LOSS_W-1:0] ratio_sat;
  logic              dead;
  logic [RTT_W-1:0]  f_probe, f_use, f_live, f_queue;
  logic              f_pvld;
  logic [RTT_W-1:0]  f_pavg;
  logic              lossy;

  assign sample  = RTT_W'(rtt_r) << RTT_FRAC_BITS;
  assign tgt_vld = in_use_r ? use_vld_r : probe_vld_r;
  assign tgt_avg = in_use_r ? use_avg_r : probe_avg_r;
  assign qdiff   = (use_avg_r < probe_avg_r) ? RTT_W'(1) : use_avg_r - probe_avg_r;
  assign ratio_sat = (|div_quo[DIV_NW-1:LOSS_W]) ? '1 : div_quo[LOSS_W-1:0];

  // operands for the divide by 10 or by 20 (as /4 then /5)
  always_comb begin
    k_sum  = '0;
    k_num  = '0;
    k_by10 = 1'b1;
    case (cmd.start_op)
      OP_RTT: begin
        k_sum = (34'(tgt_avg) << 3) + 34'(tgt_avg) + 34'(sample) + 34'd5;
        k_num = k_sum[31:0];
      end
      OP_LOSS: begin
        k_sum = 34'(loss_r) * 34'd7 + 34'(ratio_sat) * 34'd3 + 34'd5;
        k_num = k_sum[31:0];
      end
      OP_QUEUE: begin
        k_sum  = 34'(queue_r) * 34'd19 + 34'(qdiff) + 34'd10;
        k_num  = k_sum[33:2];
        k_by10 = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_run_r  <= 1'b0;
      k_done_r <= 1'b0;
    end else begin
      k_run_r  <= cmd.div_start && (cmd.start_op != OP_RATIO);
      k_done_r <= k_run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      k_num_r  <= k_num;
      k_by10_r <= k_by10;
    end
    if (k_run_r) k_prod_r <= 64'(k_num_r) * 64'(K_RECIP);
  end

  assign k_quo = k_by10_r ? k_prod_r[62:35] : k_prod_r[61:34];

  assign div_num = DIV_NW'(lost_r) << 16;
  assign div_go  = cmd.div_start && (cmd.start_op == OP_RATIO);

  nllt_div #(.NW(DIV_NW), .DW(CB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_num),
    .den   (sent_r),
    .quo   (div_quo),
    .done  (div_done)
  );

  // result view, with probe adoption
  always_comb begin
    dead   = silent_r > max_silent_r;
    f_pvld = probe_vld_r;
    f_pavg = probe_avg_r;
    if (!dead && !probe_vld_r && use_vld_r) begin
      f_pvld = 1'b1;
      f_pavg = use_avg_r;
    end
    f_probe = f_pvld ? f_pavg : '0;
    f_use   = use_vld_r ? use_avg_r : f_probe;
    f_live  = in_use_r ? f_use : f_probe;
    f_queue = queue_r;
    if (dead) begin
      f_probe = '1;
      f_use   = '1;
      f_live  = '1;
      f_queue = '0;
    end
    lossy = (clean_r < min_clean_r) || (loss_r > max_loss_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_silent_r <= MAX_SILENT_RST;
      min_clean_r  <= MIN_CLEAN_RST;
      max_loss_r   <= MAX_LOSS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SILENT: max_silent_r <= cfg_wdata[7:0];
        CFG_MIN_CLEAN:  min_clean_r  <= cfg_wdata[7:0];
        CFG_MAX_LOSS:   max_loss_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_tuser;
      rtt_r   <= in_tdata[19:0];
      round_r <= in_tdata[51:20];
      allow_r <= in_tdata[52];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.apply && func_r == FN_RESET)) begin
      in_use_r     <= 1'b0;
      allowed_r    <= 1'b1;
      pkts_r       <= '0;
      last_round_r <= '0;
      switch_cnt_r <= '0;
      probes_rx_r  <= '0;
      silent_r     <= '0;
      sent_r       <= '0;
      lost_r       <= '0;
      clean_r      <= rst_n ? min_clean_r : MIN_CLEAN_RST;
      probe_avg_r  <= '0;
      probe_vld_r  <= 1'b0;
      use_avg_r    <= '0;
      use_vld_r    <= 1'b0;
      queue_r      <= RTT_W'(1);
      loss_r       <= '0;
    end else begin
      if (cmd.apply) begin
        case (func_r)
          FN_RTT: begin
            if (probes_rx_r != '1) probes_rx_r <= probes_rx_r + 1'b1;
            if (!tgt_vld) begin
              if (in_use_r) begin
                use_avg_r <= sample;
                use_vld_r <= 1'b1;
              end else begin
                probe_avg_r <= sample;
                probe_vld_r <= 1'b1;
              end
            end
          end
          FN_PKT: begin
            in_use_r <= 1'b1;
            if (pkts_r != '1) pkts_r <= pkts_r + 1'b1;
          end
          FN_PROBE_SENT: if (sent_r != '1) sent_r <= sent_r + 1'b1;
          FN_PROBE_LOST: if (lost_r != '1) lost_r <= lost_r + 1'b1;
          FN_ROUND: begin
            if (pkts_r == '0) in_use_r <= 1'b0;
            pkts_r <= '0;
            if (probes_rx_r == '0) begin
              if (silent_r != '1) silent_r <= silent_r + 1'b1;
            end else begin
              silent_r <= '0;
            end
            probes_rx_r <= '0;
            sent_r      <= '0;
            lost_r      <= '0;
          end
          FN_TRY_SWITCH: begin
            if (switch_cnt_r == '0 || round_r == last_round_r + 1'b1) begin
              last_round_r <= round_r;
              if (switch_cnt_r != '1) switch_cnt_r <= switch_cnt_r + 1'b1;
            end else begin
              switch_cnt_r <= '0;
            end
          end
          FN_CLR_SWITCH: switch_cnt_r <= '0;
          FN_UNUSED:     in_use_r <= 1'b0;
          FN_ALLOW:      allowed_r <= allow_r;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        case (cmd.commit_op)
          OP_RTT: begin
            if (in_use_r) use_avg_r <= k_quo;
            else          probe_avg_r <= k_quo;
          end
          OP_LOSS: begin
            loss_r <= k_quo[LOSS_W-1:0];
            if (k_quo[LOSS_W-1:0] > max_loss_r) clean_r <= '0;
            else if (clean_r != '1)             clean_r <= clean_r + 1'b1;
          end
          OP_QUEUE: queue_r <= k_quo;
          default: ;
        endcase
      end
      if (cmd.queue_one) queue_r <= RTT_W'(1);
      if (cmd.form) begin
        probe_vld_r <= f_pvld;
        probe_avg_r <= f_pavg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.form) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      out_data_r <= {4'b0, loss_r, 16'(switch_cnt_r), in_use_r, allowed_r, lossy, dead,
                     f_queue, f_use, f_probe, f_live};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign sts.func       = func_r;
  assign sts.tgt_valid  = tgt_vld;
  assign sts.both_valid = use_vld_r && probe_vld_r;
  assign sts.sent_nz    = sent_r != '0;
  assign sts.div_done   = div_done || k_done_r;
  assign sts.out_free   = !out_vld_r || out_tready;

endmodule

>>> hdl/nllt_ctrl.sv
// Controller: sequences accept, event update, divider passes and result load.
// Depends on nllt_pkg.
module nllt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  nllt_pkg::dp_status_t sts,
  output nllt_pkg::dp_cmd_t    cmd
);
  import nllt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_APPLY = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_QCHK  = 5'b01000,
    ST_FORM  = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  div_op_t op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.func == FN_RTT) begin
          if (sts.tgt_valid) begin
            cmd.div_start = 1'b1;
            cmd.start_op  = OP_RTT;
            op_nxt        = OP_RTT;
            state_nxt     = ST_DIV;
          end else begin
            state_nxt = ST_QCHK;
          end
        end else if (sts.func == FN_ROUND && sts.sent_nz) begin
          cmd.div_start = 1'b1;
          cmd.start_op  = OP_RATIO;
          op_nxt        = OP_RATIO;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_FORM;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.commit    = 1'b1;
          cmd.commit_op = op_r;
          case (op_r)
            OP_RTT:   state_nxt = ST_QCHK;
            OP_RATIO: begin
              cmd.div_start = 1'b1;
              cmd.start_op  = OP_LOSS;
              op_nxt        = OP_LOSS;
            end
            default:  state_nxt = ST_FORM;
          endcase
        end
      end
      ST_QCHK: begin
        if (sts.both_valid) begin
          cmd.div_start = 1'b1;
          cmd.start_op  = OP_QUEUE;
          op_nxt        = OP_QUEUE;
          state_nxt     = ST_DIV;
        end else begin
          cmd.queue_one = 1'b1;
          state_nxt     = ST_FORM;
        end
      end
      ST_FORM: begin
        if (sts.out_free) begin
          cmd.form  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_RTT;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

>>> hdl/nexthop_latency_loss_tracker_unit.sv
// Top level of the next-hop latency and loss tracker.
// Depends on nllt_pkg, nllt_ctrl and nllt_dp (which holds nllt_div).
//
// Takes one event per item and returns one result item showing the state
// after it. Most events pass through accept, update and result load. The
// averages divide by constants through a two-stage reciprocal multiply, so an
// RTT sample with an existing average passes through update, the divide
// stages, queue check, the queue divide when both averages are valid, and
// result load; a first sample takes the same path without the average divide.
// A round tick with sent probes runs the loss ratio through the bit-serial
// divider (COUNTER_BITS+16 quotient bits) and then the loss average. The
// result load waits while the output register holds an item that is not
// taken; the next item is taken while a result waits there.
module nexthop_latency_loss_tracker_unit #(
  parameter int COUNTER_BITS = nllt_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // rtt_sample, round_number, allowed_value
  input  logic [nllt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic [nllt_pkg::FUNC_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // rtt_live, rtt_probe, rtt_used, queuing_delay, face_dead, lossy_flag,
  // allowed_flag, in_use_flag, switch_attempts, loss_average
  output logic [nllt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [nllt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nllt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nllt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  nllt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nllt_dp #(.COUNTER_BITS(COUNTER_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/nllt_chk.sv
// Port-level checker for the tracker, bound to the top level.
// Depends on nllt_pkg for port widths.
module nllt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [nllt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_dead_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[112] |->
      out_tdata[27:0] == 28'hFFFFFFF && out_tdata[55:28] == 28'hFFFFFFF &&
      out_tdata[83:56] == 28'hFFFFFFF && out_tdata[111:84] == 28'h0)
    else $error("dead face result not saturated");

  a_live_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[112] |->
      out_tdata[27:0] == (out_tdata[115] ? out_tdata[83:56] : out_tdata[55:28]))
    else $error("live rtt does not follow in-use flag");

endmodule

bind nexthop_latency_loss_tracker_unit nllt_chk u_nllt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
